// ===== rtl/core/hpt_pkg.sv =====
package hpt_pkg;

  localparam int CW     = 32;           // coordinate and entry width
  localparam int FB     = 16;           // fraction bits
  localparam int MAT_N  = 16;
  localparam int IDX_W  = 4;
  localparam int PW     = 2 * CW;       // one product
  localparam int SW     = PW + 2;       // sum of four products
  localparam int MAGW   = SW;           // magnitude of a sum
  localparam int NW     = MAGW + FB;    // scaled numerator
  localparam int QB     = CW + 1;       // quotient bits worked out
  localparam int DIV_LAT = QB + 1;
  localparam int BACK_DEPTH = DIV_LAT + 5;
  localparam int INFL_W = $clog2(BACK_DEPTH + 1);
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W = $clog2(Q_DEPTH);
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XFORM = 1'b1;

  // Diagonal of the identity; the largest positive entry if 1.0 does not fit.
  localparam logic [CW-1:0] ENTRY_ONE = (FB >= CW - 1) ? {1'b0, {(CW-1){1'b1}}}
                                                       : (CW'(1) << FB);
  localparam logic [QB-1:0] HALF = QB'(1) << (CW - 1);

  typedef logic [CW-1:0] mat_t [MAT_N];

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } pt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/homogeneous_point_transform_core.sv =====
// Vertex transform: [x y z 1] * M, then x, y and z divided by w, saturated.
// Each point runs through the multiply and add stages and the one-bit-per-stage
// pipelined dividers; a matrix load gives no result. One point per cycle while
// results are popped; a load waits until earlier points drain.
// Reset (rst_n low, synchronous): queues and pipeline empty, matrix identity.
module homogeneous_point_transform_core
  import hpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_mode,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [CW-1:0]    in_entry_value,
  input  logic [CW-1:0]    in_point_x,
  input  logic [CW-1:0]    in_point_y,
  input  logic [CW-1:0]    in_point_z,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CW-1:0]    out_x,
  output logic [CW-1:0]    out_y,
  output logic [CW-1:0]    out_z,
  output logic             out_w_zero
);

  q_stat_t q_stat;
  logic    q_push, q_pop, back_busy;
  pt_t     q_in, q_out;
  mat_t    matrix;

  hpt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .q_stat         (q_stat),
    .back_busy      (back_busy),
    .q_push         (q_push),
    .q_data         (q_in),
    .matrix         (matrix)
  );

  hpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  hpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .matrix     (matrix),
    .busy       (back_busy),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w_zero (out_w_zero)
  );

endmodule

// ===== rtl/core/hpt_queue.sv =====
module hpt_queue
  import hpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  pt_t     push_data,
  input  logic    pop,
  output pt_t     pop_data,
  output q_stat_t stat
);

  pt_t               mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/hpt_front.sv =====
module hpt_front
  import hpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_mode,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic [CW-1:0]    in_entry_value,
  input  logic [CW-1:0]    in_point_x,
  input  logic [CW-1:0]    in_point_y,
  input  logic [CW-1:0]    in_point_z,
  input  q_stat_t          q_stat,
  input  logic             back_busy,
  output logic             q_push,
  output pt_t              q_data,
  output mat_t             matrix
);

  logic             hold_v_r, hold_v_nxt;
  logic             mode_r;
  logic [IDX_W-1:0] idx_r;
  logic [CW-1:0]    val_r;
  pt_t              pt_r;
  mat_t             mat_r;
  logic             go, accept, do_load;

  // A load waits until every earlier point has left the back end, so that
  // those points still see the matrix they were sent against.
  always_comb begin
    if (mode_r == MODE_XFORM) begin
      go = !q_stat.full;
    end else begin
      go = q_stat.empty && !back_busy;
    end
  end

  assign in_full = hold_v_r && !go;
  assign accept  = in_push && !in_full;
  assign do_load = hold_v_r && go && (mode_r == MODE_LOAD);
  assign q_push  = hold_v_r && go && (mode_r == MODE_XFORM);
  assign q_data  = pt_r;
  assign matrix  = mat_r;
  assign hold_v_nxt = accept || (hold_v_r && !go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      idx_r  <= in_entry_index;
      val_r  <= in_entry_value;
      pt_r   <= '{x: in_point_x, y: in_point_y, z: in_point_z};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_N; i++) begin
        mat_r[i] <= (i % 5 == 0) ? ENTRY_ONE : '0;
      end
    end else if (do_load) begin
      mat_r[idx_r] <= val_r;
    end
  end

endmodule

// ===== rtl/core/hpt_div.sv =====
module hpt_div
  import hpt_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [MAGW-1:0] num,
  input  logic [MAGW-1:0] den,
  output logic [QB-1:0]   quo,
  output logic            ovf
);

  logic [MAGW-1:0] rem_r [DIV_LAT];
  logic [QB-1:0]   low_r [DIV_LAT];
  logic [QB-1:0]   q_r   [DIV_LAT];
  logic [MAGW-1:0] d_r   [DIV_LAT];
  logic            ovf_r [DIV_LAT];
  logic [NW-1:0]   n_sh;

  assign n_sh = {num, {FB{1'b0}}};

  // First stage: a quotient that needs more than QB bits saturates anyway.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= (n_sh >> QB) >= NW'(den);
      rem_r[0] <= MAGW'(n_sh >> QB);
      low_r[0] <= n_sh[QB-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= den;
    end
  end

  for (genvar s = 1; s < DIV_LAT; s++) begin : g_stage
    logic [MAGW:0] trial;
    logic          ge;
    assign trial = {rem_r[s-1], low_r[s-1][QB-1]};
    assign ge    = trial >= {1'b0, d_r[s-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? MAGW'(trial - {1'b0, d_r[s-1]}) : MAGW'(trial);
        low_r[s] <= low_r[s-1] << 1;
        q_r[s]   <= {q_r[s-1][QB-2:0], ge};
        d_r[s]   <= d_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];
  assign ovf = ovf_r[DIV_LAT-1];

endmodule

// ===== rtl/core/hpt_back.sv =====
module hpt_back
  import hpt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  q_stat_t       q_stat,
  input  pt_t           q_data,
  output logic          q_pop,
  input  mat_t          matrix,
  output logic          busy,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [CW-1:0] out_x,
  output logic [CW-1:0] out_y,
  output logic [CW-1:0] out_z,
  output logic          out_w_zero
);

  logic adv, out_take;

  logic                 v1_r, v2_r, v3_r, v4_r, vo_r;
  logic signed [PW-1:0] p1_r [3][4];
  logic signed [SW-1:0] t1_r [4];
  logic signed [SW-1:0] a2_r [4];
  logic signed [SW-1:0] b2_r [4];
  logic signed [SW-1:0] s3_r [4];
  logic [MAGW-1:0]      mag4_r [4];
  logic [2:0]           neg4_r;
  logic                 wz4_r;

  logic       sv_r  [DIV_LAT];
  logic       swz_r [DIV_LAT];
  logic [2:0] sng_r [DIV_LAT];

  logic [QB-1:0] quo [3];
  logic          ovf [3];
  logic [CW-1:0] res [3];
  logic [CW-1:0] ox_r, oy_r, oz_r;
  logic          owz_r;
  logic [INFL_W-1:0] infl_r, infl_nxt;
  logic [CW-1:0] pt [3];

  // The whole pipeline moves while the result slot is free or being drained.
  assign adv      = !vo_r || out_pop;
  assign q_pop    = adv && !q_stat.empty;
  assign out_take = vo_r && out_pop;
  assign pt[0] = q_data.x;
  assign pt[1] = q_data.y;
  assign pt[2] = q_data.z;

  always_comb begin
    infl_nxt = infl_r;
    if (q_pop && !out_take) begin
      infl_nxt = infl_r + INFL_W'(1);
    end else if (out_take && !q_pop) begin
      infl_nxt = infl_r - INFL_W'(1);
    end
  end
  assign busy = (infl_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      vo_r   <= 1'b0;
      infl_r <= '0;
      for (int i = 0; i < DIV_LAT; i++) begin
        sv_r[i] <= 1'b0;
      end
    end else begin
      infl_r <= infl_nxt;
      if (adv) begin
        v1_r <= !q_stat.empty;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        sv_r[0] <= v4_r;
        for (int i = 1; i < DIV_LAT; i++) begin
          sv_r[i] <= sv_r[i-1];
        end
        vo_r <= sv_r[DIV_LAT-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          p1_r[r][c] <= $signed(pt[r]) * $signed(matrix[r*4+c]);
        end
      end
      // The w row is multiplied by 1.0, a plain shift.
      for (int c = 0; c < 4; c++) begin
        t1_r[c] <= {{(SW-CW-FB){matrix[12+c][CW-1]}}, matrix[12+c], {FB{1'b0}}};
      end
      for (int c = 0; c < 4; c++) begin
        a2_r[c] <= SW'(p1_r[0][c]) + SW'(p1_r[1][c]);
        b2_r[c] <= SW'(p1_r[2][c]) + t1_r[c];
        s3_r[c] <= a2_r[c] + b2_r[c];
      end
      for (int c = 0; c < 4; c++) begin
        mag4_r[c] <= s3_r[c][SW-1] ? MAGW'(-s3_r[c]) : MAGW'(s3_r[c]);
      end
      for (int c = 0; c < 3; c++) begin
        neg4_r[c] <= s3_r[c][SW-1] ^ s3_r[3][SW-1];
      end
      wz4_r <= (s3_r[3] == '0);
      swz_r[0] <= wz4_r;
      sng_r[0] <= neg4_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        swz_r[i] <= swz_r[i-1];
        sng_r[i] <= sng_r[i-1];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    logic          neg;
    logic [QB-1:0] limit, qsat;
    hpt_div u_div (
      .clk (clk),
      .en  (adv),
      .num (mag4_r[c]),
      .den (mag4_r[3]),
      .quo (quo[c]),
      .ovf (ovf[c])
    );
    assign neg   = sng_r[DIV_LAT-1][c];
    assign limit = neg ? HALF : HALF - QB'(1);
    assign qsat  = (ovf[c] || quo[c] > limit) ? limit : quo[c];
    assign res[c] = swz_r[DIV_LAT-1] ? '0 : (neg ? CW'(-qsat) : CW'(qsat));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r  <= res[0];
      oy_r  <= res[1];
      oz_r  <= res[2];
      owz_r <= swz_r[DIV_LAT-1];
    end
  end

  assign out_empty  = !vo_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_z      = oz_r;
  assign out_w_zero = owz_r;

endmodule

// ===== rtl/core/hpt_checker.sv =====
module hpt_checker
  import hpt_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          in_full,
  input logic          out_empty,
  input logic          out_pop,
  input logic [CW-1:0] out_x,
  input logic [CW-1:0] out_y,
  input logic [CW-1:0] out_z,
  input logic          out_w_zero
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  a_free_after_reset: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  // A zero w must come with zero coordinates.
  a_wzero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_w_zero) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("w zero beat with nonzero coordinates");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_x) && $stable(out_y)
                                  && $stable(out_z) && $stable(out_w_zero)))
    else $error("waiting result beat changed");

endmodule

bind homogeneous_point_transform_core hpt_checker u_hpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_full    (in_full),
  .out_empty  (out_empty),
  .out_pop    (out_pop),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_z      (out_z),
  .out_w_zero (out_w_zero)
);

// ===== tb/tb_homogeneous_point_transform_core.sv =====
`timescale 1ns / 100ps

module tb_homogeneous_point_transform_core;
  import hpt_pkg::*;

  typedef struct {
    logic        mode;
    logic [3:0]  idx;
    logic [31:0] value;
    logic [31:0] x, y, z;
    bit          typed;
    logic [31:0] ex, ey, ez;
    logic        ewz;
  } stim_row_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        wz;
  } vertex_t;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MAXN = 32'h8000_0000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic             in_mode = MODE_LOAD;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic [CW-1:0]    in_entry_value = '0;
  logic [CW-1:0]    in_point_x = '0;
  logic [CW-1:0]    in_point_y = '0;
  logic [CW-1:0]    in_point_z = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [CW-1:0]    out_x, out_y, out_z;
  logic             out_w_zero;

  homogeneous_point_transform_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [31:0] model_matrix [16];
  vertex_t     pending_vertices [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;
  stim_row_t   directed [$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [31:0] divide_saturate(logic signed [127:0] n,
                                                   logic signed [127:0] w);
    logic         neg;
    logic [127:0] nm, wm, q, lim;
    neg = n[127] ^ w[127];
    nm  = n[127] ? -n : n;
    wm  = w[127] ? -w : w;
    q   = (nm << FB) / wm;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic vertex_t transform_point(logic [31:0] px, logic [31:0] py,
                                              logic [31:0] pz);
    logic signed [127:0] vx, vy, vz, vone, s[4];
    vertex_t r;
    vx = $signed(px);
    vy = $signed(py);
    vz = $signed(pz);
    vone = 128'sd1 <<< FB;
    for (int j = 0; j < 4; j++)
      s[j] = vx * $signed(model_matrix[j]) + vy * $signed(model_matrix[4 + j])
           + vz * $signed(model_matrix[8 + j]) + vone * $signed(model_matrix[12 + j]);
    if (s[3] == 0) begin
      r = '{x: '0, y: '0, z: '0, wz: 1'b1};
    end else begin
      r.x = divide_saturate(s[0], s[3]);
      r.y = divide_saturate(s[1], s[3]);
      r.z = divide_saturate(s[2], s[3]);
      r.wz = 1'b0;
    end
    return r;
  endfunction

  // Drives one item from the falling edge and holds it until the block takes it.
  task automatic send_item(stim_row_t row);
    vertex_t v;
    in_push        <= 1'b1;
    in_mode        <= row.mode;
    in_entry_index <= row.idx;
    in_entry_value <= row.value;
    in_point_x     <= row.x;
    in_point_y     <= row.y;
    in_point_z     <= row.z;
    do @(posedge clk); while (in_full);
    if (row.mode == MODE_LOAD) begin
      model_matrix[row.idx] = row.value;
    end else begin
      v = transform_point(row.x, row.y, row.z);
      if (row.typed) v = '{x: row.ex, y: row.ey, z: row.ez, wz: row.ewz};
      pending_vertices.push_back(v);
    end
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      2: return ($urandom_range(0, 1) != 0) ? MAXP : MAXN;
      default: return '0;
    endcase
  endfunction

  function automatic stim_row_t row_of(logic m, logic [3:0] i, logic [31:0] v,
                                       logic [31:0] x, logic [31:0] y, logic [31:0] z);
    stim_row_t r;
    r = '{mode: m, idx: i, value: v, x: x, y: y, z: z, typed: 1'b0,
          ex: '0, ey: '0, ez: '0, ewz: 1'b0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic [31:0] ex, logic [31:0] ey,
                                          logic [31:0] ez, logic ewz);
    stim_row_t r;
    r = row_of(MODE_XFORM, '0, '0, x, y, z);
    r.typed = 1'b1;
    r.ex = ex; r.ey = ey; r.ez = ez; r.ewz = ewz;
    return r;
  endfunction

  initial begin
    stim_row_t r;
    int burst;
    int gap;
    for (int i = 0; i < 16; i++) model_matrix[i] = (i % 5 == 0) ? ENTRY_ONE : '0;

    // Identity after reset passes points through unchanged.
    directed.push_back(typed_row(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000,
                                 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 1'b0));
    directed.push_back(typed_row(MAXP, MAXN, 32'h0, MAXP, MAXN, 32'h0, 1'b0));
    // Point fields of a load and entry fields of a transform are don't-cares.
    r = row_of(MODE_XFORM, 4'hf, MAXN, 32'h5, 32'h7, 32'h9);
    r.typed = 1'b1; r.ex = 32'h5; r.ey = 32'h7; r.ez = 32'h9;
    directed.push_back(r);
    directed.push_back(row_of(MODE_LOAD, 4'd0, 32'h0002_0000, MAXP, MAXN, MAXP));
    directed.push_back(row_of(MODE_XFORM, '0, '0, MAXP, 32'h1, 32'h1));
    directed.push_back(row_of(MODE_XFORM, '0, '0, MAXN, 32'h1, 32'h1));
    directed.push_back(row_of(MODE_LOAD, 4'd1, MAXP, '0, '0, '0));
    directed.push_back(row_of(MODE_LOAD, 4'd6, MAXN, '0, '0, '0));
    directed.push_back(row_of(MODE_XFORM, '0, '0, MAXN, MAXP, 32'hffff_ffff));
    directed.push_back(row_of(MODE_LOAD, 4'd14, MAXN, '0, '0, '0));
    directed.push_back(row_of(MODE_XFORM, '0, '0, MAXP, MAXN, MAXP));
    // Zero w: clear the last column, so w is zero for every point.
    directed.push_back(row_of(MODE_LOAD, 4'd15, 32'h0, '0, '0, '0));
    directed.push_back(typed_row(32'h1234_5678, MAXN, MAXP, '0, '0, '0, 1'b1));
    directed.push_back(row_of(MODE_LOAD, 4'd11, 32'h0000_8000, '0, '0, '0));
    directed.push_back(row_of(MODE_XFORM, '0, '0, 32'h1, 32'h1, 32'h0000_0001));
    directed.push_back(row_of(MODE_XFORM, '0, '0, 32'h1, 32'h1, 32'hffff_ffff));
    directed.push_back(row_of(MODE_LOAD, 4'd15, 32'hffff_0000, '0, '0, '0));
    directed.push_back(row_of(MODE_XFORM, '0, '0, MAXP, MAXP, MAXP));
    for (int i = 0; i < 16; i++)
      directed.push_back(row_of(MODE_LOAD, 4'(i), (i % 5 == 0) ? ENTRY_ONE : '0,
                                '0, '0, '0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_item(directed[i]);

    burst = 0;
    for (int n = 0; n < 850; n++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_push <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      burst--;
      if ($urandom_range(0, 9) == 0)
        r = row_of(MODE_LOAD, 4'($urandom_range(0, 15)),
                   rand_value($urandom_range(0, 7) < 3 ? 0 : $urandom_range(1, 3)),
                   $urandom, $urandom, $urandom);
      else if ($urandom_range(0, 3) == 0)
        r = row_of(MODE_XFORM, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
      else
        r = row_of(MODE_XFORM, 4'($urandom), $urandom,
                   rand_value($urandom_range(0, 2)), rand_value($urandom_range(1, 2)),
                   rand_value($urandom_range(0, 3)));
      send_item(r);
    end
    in_push <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: runs of pops and stalls, plus one long hold-off to back up the block.
  initial begin
    int cyc, run;
    bit popping;
    cyc = 0; run = 0; popping = 1'b1;
    forever begin
      @(negedge clk);
      cyc++;
      if (run == 0) begin
        popping = !popping;
        run = popping ? $urandom_range(1, 60) : $urandom_range(1, 8);
      end
      run--;
      out_pop <= (cyc >= 1500 && cyc < 1800) ? 1'b0 : popping;
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("beat with no pending item, out_x", out_x, 'x);
      end else begin
        want = pending_vertices.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (out_w_zero !== want.wz) report_mismatch("out_w_zero", out_w_zero, want.wz);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done && pending_vertices.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_vertices.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hpt_pkg.sv
rtl/core/hpt_queue.sv
rtl/core/hpt_front.sv
rtl/core/hpt_div.sv
rtl/core/hpt_back.sv
rtl/core/homogeneous_point_transform_core.sv
rtl/core/hpt_checker.sv
tb/tb_homogeneous_point_transform_core.sv
